>>> hdl/isii_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isii_pkg
// Shared constants and types of the integral / squared integral image block.
// ----------------------------------------------------------------------------
package isii_pkg;

    // Frame limits and position counters
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int DIM_W      = 11;

    // Configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [DIM_W-1:0]     WIDTH_RESET      = 11'd640;
    localparam logic [DIM_W-1:0]     HEIGHT_RESET     = 11'd480;

    // Datapath widths
    localparam int CHAN_W     = 8;
    localparam int CSUM_W     = 10;   // red + green + blue
    localparam int GREY_W     = 8;
    localparam int SQ_W       = 2 * GREY_W;
    localparam int ROW_SUM_W  = 18;
    localparam int ROW_SQ_W   = 26;
    localparam int LINE_SUM_W = 28;
    localparam int LINE_SQ_W  = 37;
    localparam int OUT_SQ_W   = 36;
    localparam int LINE_W     = LINE_SUM_W + LINE_SQ_W;

    // Divide by three: (x * 683) >> 11 is exact for x up to 765
    localparam int RECIP_W     = 10;
    localparam int RECIP_SHIFT = 11;
    localparam logic [RECIP_W-1:0] RECIP_3 = 10'd683;
    localparam int PROD_W      = CSUM_W + RECIP_W;

    // Accepted items that can be in flight: three inner stages plus output
    localparam int PIPE_DEPTH = 4;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    // Per-pixel control that travels down the pipeline
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             row_nz;     // not the first row: add line store
        logic             row_start;  // column 0: restart row sums
        logic             last;       // last pixel of the frame
    } pix_ctl_t;

    // Zero acts as one, above the maximum saturates
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

endpackage

>>> hdl/isii_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isii_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module isii_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/integral_and_square_integral_image.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integral_and_square_integral_image
// Integral image and squared integral image of a raster-order RGB stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns one
// beat per pixel; each pixel passes through stages 1, 2 and 3 and its result
// is offered from the output register. Grey is the truncated mean of the three
// channels. The line store is a single 65-bit wide, MAX_WIDTH deep memory
// holding the previous row's sum and square sum per column; it is read when a
// pixel is accepted and written back from stage 3, and the last three
// write-backs are forwarded so narrow rows run at full rate. Entries are not
// cleared after reset: a frame's first row does not use them. A back-pressured
// output freezes the whole pipeline, bubbles included, while the output waits.
module integral_and_square_integral_image (
    input  logic        clk,
    input  logic        rst_n,
    // pixel input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic        s_tuser,   // [0] frame_start
    // sums output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [27:0] grey_sum, [63:28] grey_square_sum
    output logic        m_tlast,   // frame_end
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import isii_pkg::*;

    // Configuration
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] eff_width;
    logic [DIM_W-1:0] eff_height;

    // Position
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [DIM_W:0]   col_inc;
    logic [DIM_W:0]   row_inc;
    logic             row_end;
    logic             last_row;

    // Handshake
    logic advance;
    logic accept;

    // Stage 1
    logic              s1_valid_reg;
    pix_ctl_t          s1_ctl_reg;
    pix_ctl_t          s0_ctl;
    logic [CSUM_W-1:0] s1_csum_reg;
    logic [CSUM_W-1:0] s0_csum;
    logic [PROD_W-1:0] s1_prod;
    logic [GREY_W-1:0] s1_grey;

    // Stage 2
    logic                 s2_valid_reg;
    pix_ctl_t             s2_ctl_reg;
    logic [GREY_W-1:0]    s2_grey_reg;
    logic [LINE_W-1:0]    s2_line_reg;
    logic [SQ_W-1:0]      s2_sq;
    logic [ROW_SUM_W-1:0] row_sum_reg;
    logic [ROW_SUM_W-1:0] row_sum_next;
    logic [ROW_SQ_W-1:0]  row_sq_reg;
    logic [ROW_SQ_W-1:0]  row_sq_next;

    // Stage 3
    logic                  s3_valid_reg;
    pix_ctl_t              s3_ctl_reg;
    logic [ROW_SUM_W-1:0]  s3_row_sum_reg;
    logic [ROW_SQ_W-1:0]   s3_row_sq_reg;
    logic [LINE_W-1:0]     s3_line_reg;
    logic [LINE_W-1:0]     s3_line_fwd;
    logic [LINE_SUM_W-1:0] s3_above_sum;
    logic [LINE_SQ_W-1:0]  s3_above_sq;
    logic [LINE_SUM_W-1:0] s3_sum;
    logic [LINE_SQ_W-1:0]  s3_sq;
    logic                  wr_en;

    // Write-back history for forwarding, newest in entry 0
    logic [2:0]        hist_valid_reg;
    logic [COL_W-1:0]  hist_addr_reg [3];
    logic [LINE_W-1:0] hist_data_reg [3];

    // Output register
    logic                  out_valid_reg;
    logic [LINE_SUM_W-1:0] out_sum_reg;
    logic [OUT_SQ_W-1:0]   out_sq_reg;
    logic                  out_last_reg;

    logic [LINE_W-1:0] ram_rd_data;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_width  = clamp_dim(width_reg, DIM_W'(MAX_WIDTH));
    assign eff_height = clamp_dim(height_reg, DIM_W'(MAX_HEIGHT));

    // ---------------- stage 0: position and line store read ----------------
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    assign cur_col  = s_tuser ? '0 : col_reg;
    assign cur_row  = s_tuser ? '0 : row_reg;
    assign col_inc  = (DIM_W + 1)'(cur_col) + 1'b1;
    assign row_inc  = (DIM_W + 1)'(cur_row) + 1'b1;
    assign row_end  = col_inc >= {1'b0, eff_width};
    assign last_row = row_inc >= {1'b0, eff_height};

    assign col_next = row_end ? '0 : col_inc[COL_W-1:0];
    assign row_next = !row_end ? cur_row : (last_row ? '0 : row_inc[ROW_W-1:0]);

    assign s0_ctl.col       = cur_col;
    assign s0_ctl.row_nz    = cur_row != '0;
    assign s0_ctl.row_start = cur_col == '0;
    assign s0_ctl.last      = row_end && last_row;

    assign s0_csum = CSUM_W'(s_tdata[7:0]) + CSUM_W'(s_tdata[15:8])
                   + CSUM_W'(s_tdata[23:16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- stage 1: divide by three ----------------
    assign s1_prod = PROD_W'(s1_csum_reg) * PROD_W'(RECIP_3);
    assign s1_grey = s1_prod[RECIP_SHIFT +: GREY_W];

    // ---------------- stage 2: square and row running sums ----------------
    assign s2_sq        = SQ_W'(s2_grey_reg) * SQ_W'(s2_grey_reg);
    assign row_sum_next = (s2_ctl_reg.row_start ? '0 : row_sum_reg)
                        + ROW_SUM_W'(s2_grey_reg);
    assign row_sq_next  = (s2_ctl_reg.row_start ? '0 : row_sq_reg)
                        + ROW_SQ_W'(s2_sq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_sum_reg <= '0;
            row_sq_reg  <= '0;
        end
        else if (advance && s2_valid_reg)
        begin
            row_sum_reg <= row_sum_next;
            row_sq_reg  <= row_sq_next;
        end
    end

    // ---------------- stage 3: add the row above, write back ----------------
    // newest matching write-back wins over the memory read
    always_comb
    begin
        s3_line_fwd = s3_line_reg;
        if (hist_valid_reg[2] && hist_addr_reg[2] == s3_ctl_reg.col)
            s3_line_fwd = hist_data_reg[2];
        if (hist_valid_reg[1] && hist_addr_reg[1] == s3_ctl_reg.col)
            s3_line_fwd = hist_data_reg[1];
        if (hist_valid_reg[0] && hist_addr_reg[0] == s3_ctl_reg.col)
            s3_line_fwd = hist_data_reg[0];
    end

    assign s3_above_sum = s3_ctl_reg.row_nz ? s3_line_fwd[LINE_SUM_W-1:0] : '0;
    assign s3_above_sq  = s3_ctl_reg.row_nz ? s3_line_fwd[LINE_W-1:LINE_SUM_W] : '0;
    assign s3_sum       = LINE_SUM_W'(s3_row_sum_reg) + s3_above_sum;
    assign s3_sq        = LINE_SQ_W'(s3_row_sq_reg) + s3_above_sq;
    assign wr_en        = advance && s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            hist_valid_reg <= {hist_valid_reg[1:0], 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_addr_reg[0] <= s3_ctl_reg.col;
            hist_data_reg[0] <= {s3_sq, s3_sum};
            hist_addr_reg[1] <= hist_addr_reg[0];
            hist_data_reg[1] <= hist_data_reg[0];
            hist_addr_reg[2] <= hist_addr_reg[1];
            hist_data_reg[2] <= hist_data_reg[1];
        end
    end

    // ---------------- pipeline valids ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // ---------------- pipeline payload ----------------
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ctl_reg     <= s0_ctl;
            s1_csum_reg    <= s0_csum;
            s2_ctl_reg     <= s1_ctl_reg;
            s2_grey_reg    <= s1_grey;
            s2_line_reg    <= ram_rd_data;
            s3_ctl_reg     <= s2_ctl_reg;
            s3_row_sum_reg <= row_sum_next;
            s3_row_sq_reg  <= row_sq_next;
            s3_line_reg    <= s2_line_reg;
            out_sum_reg    <= s3_sum;
            out_sq_reg     <= s3_sq[OUT_SQ_W-1:0];
            out_last_reg   <= s3_ctl_reg.last;
        end
    end

    // ---------------- line store ----------------
    isii_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s3_ctl_reg.col),
        .wr_data ({s3_sq, s3_sum}),
        .rd_en   (accept),
        .rd_addr (cur_col),
        .rd_data (ram_rd_data)
    );

    // ---------------- outputs ----------------
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_sq_reg, out_sum_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> hdl/isii_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isii_check
// Port-level checks of the integral image block, bound to its top level.
// ----------------------------------------------------------------------------
module isii_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);
    import isii_pkg::*;

    logic             in_beat;
    logic             out_beat;
    logic [CNT_W-1:0] pending_reg;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // Pixels accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_beat && !out_beat)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Input is taken exactly when the output register can move
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // No result without a pixel behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != '0)
        else $error("result beat with no pixel pending");

    // Pipeline never holds more pixels than it has stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more pixels in flight than pipeline stages");

endmodule

bind integral_and_square_integral_image isii_check u_isii_check (.*);
